// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the 2x2 matrix power block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that implies another in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/m2pow_pkg.sv =====
// Package for the 2x2 matrix power block: item types, constants and the
// binary32 normalize and round helpers shared by the multiply and add units.
package m2pow_pkg;

  localparam int EXP_BITS    = 32;
  localparam int STORE_DEPTH = 32;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
  localparam logic [31:0] FP_ZERO   = 32'h0000_0000;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [31:0] in_row1_col1;
    logic [31:0] in_row1_col2;
    logic [31:0] in_row2_col1;
    logic [31:0] in_row2_col2;
    logic [EXP_BITS-1:0] exponent;
  } req_t;

  typedef struct packed {
    logic [31:0] out_row1_col1;
    logic [31:0] out_row1_col2;
    logic [31:0] out_row2_col1;
    logic [31:0] out_row2_col2;
  } rsp_t;

  typedef struct packed {
    logic [31:0] e11;
    logic [31:0] e12;
    logic [31:0] e21;
    logic [31:0] e22;
  } mat_t;

  typedef struct packed {
    logic [5:0]  lz;
    logic [63:0] val;
  } norm_t;

  // Left-justifies a nonzero word in six binary steps and reports the shift.
  function automatic norm_t normalize64(logic [63:0] x);
    norm_t n;
    n.lz  = '0;
    n.val = x;
    if (n.val[63:32] == '0) begin n.val = n.val << 32; n.lz[5] = 1'b1; end
    if (n.val[63:48] == '0) begin n.val = n.val << 16; n.lz[4] = 1'b1; end
    if (n.val[63:56] == '0) begin n.val = n.val << 8;  n.lz[3] = 1'b1; end
    if (n.val[63:60] == '0) begin n.val = n.val << 4;  n.lz[2] = 1'b1; end
    if (n.val[63:62] == '0) begin n.val = n.val << 2;  n.lz[1] = 1'b1; end
    if (n.val[63] == 1'b0)  begin n.val = n.val << 1;  n.lz[0] = 1'b1; end
    return n;
  endfunction

  // Rounds 1.sig * 2^(bexp-127) to nearest even. sig[26] is the leading one,
  // sig[2:0] are guard, round and sticky. Handles overflow and subnormals.
  function automatic logic [31:0] round_pack(logic sign, logic signed [9:0] bexp,
                                             logic [26:0] sig);
    logic signed [9:0] d;
    logic [4:0]  sh;
    logic [53:0] wide;
    logic [26:0] s;
    logic [7:0]  ef;
    logic        inc;
    logic [30:0] mag;
    d    = 10'sd1 - bexp;
    sh   = (d > 10'sd27) ? 5'd27 : d[4:0];
    wide = {sig, 27'b0} >> sh;
    if (bexp < 10'sd1) begin
      s  = {wide[53:28], wide[27] | (|wide[26:0])};
      ef = 8'd0;
    end else begin
      s  = sig;
      ef = bexp[7:0];
    end
    inc = s[2] & (s[1] | s[0] | s[3]);
    mag = {ef, s[25:3]} + {30'b0, inc};
    if (bexp >= 10'sd255) begin
      return {sign, 8'hFF, 23'b0};
    end
    return {sign, mag};
  endfunction

  function automatic logic [31:0] canon(logic [31:0] x);
    if ((x[30:23] == 8'hFF) && (x[22:0] != '0)) begin
      return CANON_NAN;
    end
    return x;
  endfunction

endpackage

// ===== rtl/m2pow_store.sv =====
// Square store: one entry per square A^(2^k), one write and one read port.
// Read data is registered. Depends on m2pow_pkg.
module m2pow_store import m2pow_pkg::*; (
  input  logic                clk,
  input  logic                we,
  input  logic [STORE_AW-1:0] waddr,
  input  mat_t                wdata,
  input  logic                re,
  input  logic [STORE_AW-1:0] raddr,
  output mat_t                rdata
);

  mat_t mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/m2pow_fmul.sv =====
// Two-stage binary32 multiplier: exact product, then normalize and round.
// Depends on m2pow_pkg for the shared normalize and round helpers.
module m2pow_fmul import m2pow_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0] ea, eb;
  logic [23:0] ma, mb;

  logic              p_sign, p_nan, p_inf;
  logic [47:0]       p_prod;
  logic signed [9:0] p_exp;

  norm_t       n;
  logic [26:0] sig;

  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    a_zero = a[30:0] == '0;
    b_zero = b[30:0] == '0;
    ea = (a[30:23] == '0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == '0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != '0, a[22:0]};
    mb = {b[30:23] != '0, b[22:0]};
  end

  always_ff @(posedge clk) begin
    p_sign <= a[31] ^ b[31];
    p_nan  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    p_inf  <= a_inf | b_inf;
    p_prod <= ma * mb;
    p_exp  <= $signed({2'b0, ea}) + $signed({2'b0, eb}) - 10'sd126;
  end

  always_comb begin
    n   = normalize64({p_prod, 16'b0});
    sig = {n.val[63:38], |n.val[37:0]};
  end

  always_ff @(posedge clk) begin
    if (p_nan) begin
      y <= CANON_NAN;
    end else if (p_inf) begin
      y <= {p_sign, 8'hFF, 23'b0};
    end else if (p_prod == '0) begin
      y <= {p_sign, 31'b0};
    end else begin
      y <= round_pack(p_sign, p_exp - $signed({4'b0, n.lz}), sig);
    end
  end

endmodule

// ===== rtl/m2pow_fadd.sv =====
// Two-stage binary32 adder: align and add, then normalize and round.
// Depends on m2pow_pkg for the shared normalize and round helpers.
module m2pow_fadd import m2pow_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic a_nan, b_nan, a_inf, b_inf;
  logic [31:0] x, w;
  logic [7:0]  ex, ew, d;
  logic [4:0]  dsh;
  logic [23:0] mx, mw;
  logic [53:0] wide;
  logic [26:0] x27, w27;
  logic        sub;

  logic              s_sign, s_sub, s_nan, s_inf, s_inf_sign;
  logic [27:0]       s_sum;
  logic signed [9:0] s_exp;

  norm_t       n;
  logic [26:0] sig;

  always_comb begin
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    // Larger magnitude goes to x so the difference never goes negative.
    if (a[30:0] < b[30:0]) begin
      x = b;
      w = a;
    end else begin
      x = a;
      w = b;
    end
    ex   = (x[30:23] == '0) ? 8'd1 : x[30:23];
    ew   = (w[30:23] == '0) ? 8'd1 : w[30:23];
    mx   = {x[30:23] != '0, x[22:0]};
    mw   = {w[30:23] != '0, w[22:0]};
    d    = ex - ew;
    dsh  = (d > 8'd27) ? 5'd27 : d[4:0];
    wide = {mw, 3'b0, 27'b0} >> dsh;
    x27  = {mx, 3'b0};
    w27  = {wide[53:28], wide[27] | (|wide[26:0])};
    sub  = x[31] ^ w[31];
  end

  always_ff @(posedge clk) begin
    s_sign     <= x[31];
    s_sub      <= sub;
    s_nan      <= a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
    s_inf      <= a_inf | b_inf;
    s_inf_sign <= a_inf ? a[31] : b[31];
    s_sum      <= sub ? ({1'b0, x27} - {1'b0, w27}) : ({1'b0, x27} + {1'b0, w27});
    s_exp      <= $signed({2'b0, ex}) + 10'sd1;
  end

  always_comb begin
    n   = normalize64({s_sum, 36'b0});
    sig = {n.val[63:38], |n.val[37:0]};
  end

  always_ff @(posedge clk) begin
    if (s_nan) begin
      y <= CANON_NAN;
    end else if (s_inf) begin
      y <= {s_inf_sign, 8'hFF, 23'b0};
    end else if (s_sum == '0) begin
      // Exact cancellation gives +0 under round to nearest.
      y <= {s_sign & ~s_sub, 31'b0};
    end else begin
      y <= round_pack(s_sign, s_exp - $signed({4'b0, n.lz}), sig);
    end
  end

endmodule

// ===== rtl/matrix2_power_by_squaring_top.sv =====
// Raises a 2x2 matrix of binary32 values to an unsigned power by squaring.
// The block takes one item at a time. It first forms the squares A^(2^k) up
// to the top set bit of the exponent, one matrix product each, and keeps
// them in a 32-entry square store. It then walks the exponent from the top
// bit down and, for each set bit, multiplies the stored square into the
// running result from the left, starting from the identity. Each matrix
// product issues its four elements on consecutive cycles into two shared
// pipelined multipliers feeding one pipelined adder; a multiply step
// first selects and then reads the store entry, and every clear exponent
// bit below the top is skipped in the select state. Exponent zero returns
// the identity in the cycle after acceptance. Every product and sum rounds
// to nearest even, subnormals are kept, and NaN results come out as
// 0x7FC00000. The result is held until taken, and the next item is
// accepted once it is gone.
`include "assert_macros.svh"
module matrix2_power_by_squaring_top import m2pow_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PROD   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_MSEL   = 3'd3;
  localparam logic [2:0] ST_MRD    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // Control state.
  logic [2:0]          state;
  logic                sq_phase;
  logic [STORE_AW-1:0] k;
  logic [2:0]          cnt;

  // Item payload: exponent, its shifted copy, operands and result.
  logic [EXP_BITS-1:0] e;
  logic [EXP_BITS-1:0] esh;
  mat_t                opl;
  mat_t                opr;
  mat_t                r;
  logic [31:0]         pres [4];
  mat_t                pmat;
  mat_t                in_mat;

  logic                accept;
  logic                store_we;
  logic [STORE_AW-1:0] store_waddr;
  mat_t                store_wdata;
  logic                rd_en;
  mat_t                rdata;

  logic        row, col;
  logic [31:0] mul_a0, mul_b0, mul_a1, mul_b1, prod0, prod1, sum;

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_DONE);
  assign accept    = req_valid && req_ready;

  assign in_mat = '{e11: req.in_row1_col1, e12: req.in_row1_col2,
                    e21: req.in_row2_col1, e22: req.in_row2_col2};
  assign pmat   = '{e11: pres[0], e12: pres[1], e21: pres[2], e22: pres[3]};

  // The input itself is square zero; later squares are written as they
  // commit. Reads happen only in the multiply walk, after all writes.
  assign store_we    = (accept && (req.exponent != '0)) ||
                       ((state == ST_COMMIT) && sq_phase);
  assign store_waddr = (state == ST_IDLE) ? '0 : k;
  assign store_wdata = (state == ST_IDLE) ? in_mat : pmat;
  assign rd_en       = (state == ST_MSEL) && e[k];

  m2pow_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .re    (rd_en),
    .raddr (k),
    .rdata (rdata)
  );

  // Element cnt is row cnt[1], column cnt[0]; it needs row of the left
  // operand against column of the right.
  assign row = cnt[1];
  assign col = cnt[0];
  assign mul_a0 = row ? opl.e21 : opl.e11;
  assign mul_b0 = col ? opr.e12 : opr.e11;
  assign mul_a1 = row ? opl.e22 : opl.e12;
  assign mul_b1 = col ? opr.e22 : opr.e21;

  m2pow_fmul u_mul0 (.clk(clk), .a(mul_a0), .b(mul_b0), .y(prod0));
  m2pow_fmul u_mul1 (.clk(clk), .a(mul_a1), .b(mul_b1), .y(prod1));
  m2pow_fadd u_add  (.clk(clk), .a(prod0),  .b(prod1),  .y(sum));

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sq_phase <= 1'b0;
      k        <= '0;
      cnt      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            k   <= '0;
            cnt <= '0;
            if (req.exponent == '0) begin
              state <= ST_DONE;
            end else if ((req.exponent >> 1) != '0) begin
              k        <= STORE_AW'(1);
              sq_phase <= 1'b1;
              state    <= ST_PROD;
            end else begin
              sq_phase <= 1'b0;
              state    <= ST_MSEL;
            end
          end
        end
        ST_PROD: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          cnt <= '0;
          if (sq_phase) begin
            if ((esh >> 1) != '0) begin
              k     <= k + STORE_AW'(1);
              state <= ST_PROD;
            end else begin
              sq_phase <= 1'b0;
              state    <= ST_MSEL;
            end
          end else if (k == '0) begin
            state <= ST_DONE;
          end else begin
            k     <= k - STORE_AW'(1);
            state <= ST_MSEL;
          end
        end
        ST_MSEL: begin
          if (e[k]) begin
            state <= ST_MRD;
          end else if (k == '0) begin
            state <= ST_DONE;
          end else begin
            k <= k - STORE_AW'(1);
          end
        end
        ST_MRD: begin
          cnt   <= '0;
          state <= ST_PROD;
        end
        ST_DONE: begin
          if (rsp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      e   <= req.exponent;
      esh <= req.exponent >> 1;
      r   <= '{e11: FP_ONE, e12: FP_ZERO, e21: FP_ZERO, e22: FP_ONE};
      opl <= in_mat;
      opr <= in_mat;
    end
    // The adder output for element i is taken into pres[i] once it has passed the multiplier and adder registers.
    if ((state == ST_PROD) && cnt[2]) begin
      pres[cnt[1:0]] <= sum;
    end
    if (state == ST_COMMIT) begin
      if (sq_phase) begin
        esh <= esh >> 1;
        opl <= pmat;
        opr <= pmat;
      end else begin
        r <= pmat;
      end
    end
    if (state == ST_MRD) begin
      opl <= rdata;
      opr <= r;
    end
  end

  assign rsp.out_row1_col1 = canon(r.e11);
  assign rsp.out_row1_col2 = canon(r.e12);
  assign rsp.out_row2_col1 = canon(r.e21);
  assign rsp.out_row2_col2 = canon(r.e22);

  `ASSERT_ALWAYS(a_one_item_in_flight, !(req_ready && rsp_valid), "took an item while a result waits")
  `ASSERT_IMPLIES(a_store_write_phase, store_we, sq_phase || (state == ST_IDLE), "store written during multiply walk")
  `ASSERT_NEXT(a_last_commit_done, (state == ST_COMMIT) && !sq_phase && (k == '0), rsp_valid, "last product did not finish the item")
  `ASSERT_NEXT(a_result_held, rsp_valid && !rsp_ready, rsp_valid && $stable(r), "result changed before it was taken")

endmodule
